// ----- src/bfks_pkg.sv -----
// ----------------------------------------------------------------------------
// bfks_pkg: shared types and constants
// Request and result payloads, request and status codes, and defaults for the
// bounded key/value queue with key search.
// ----------------------------------------------------------------------------
package bfks_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned STAT_W    = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_SEARCH  = 3'd2,
    MODE_REPLACE = 3'd3,
    MODE_EDIT    = 3'd4,
    MODE_READ    = 3'd5,
    MODE_CLEAR   = 3'd6
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef struct packed {
    mode_e                   mode;
    logic signed [KEY_W-1:0] key_in;
    logic signed [KEY_W-1:0] old_key;
    logic [VAL_W-1:0]        value_word;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic signed [KEY_W-1:0] key_out;
    logic [VAL_W-1:0]        value_out;
    logic [OCC_W-1:0]        occupancy;
    logic                    last;
  } rsp_t;

  function automatic rsp_t mk_rsp(status_e st, logic [KEY_W-1:0] key,
                                  logic [VAL_W-1:0] val, logic [OCC_W-1:0] occ,
                                  logic lst);
    rsp_t r;
    r.status    = st;
    r.key_out   = key;
    r.value_out = val;
    r.occupancy = occ;
    r.last      = lst;
    return r;
  endfunction

endpackage

// ----- src/bfks_if.sv -----
// ----------------------------------------------------------------------------
// bfks_if: channel interfaces
// Valid/ready channels for requests, results and the capacity write.
// ----------------------------------------------------------------------------
interface bfks_req_if;
  logic          valid;
  logic          ready;
  bfks_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfks_rsp_if;
  logic          valid;
  logic          ready;
  bfks_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfks_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bfks_pkg::CAP_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/bfks_store.sv -----
// ----------------------------------------------------------------------------
// bfks_store: entry memory
// Key and value storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfks_store #(
  parameter int unsigned DEPTH = bfks_pkg::DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [bfks_pkg::KEY_W-1:0]    wr_key_i,
  input  logic [bfks_pkg::VAL_W-1:0]    wr_val_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [bfks_pkg::KEY_W-1:0]    rd_key_o,
  output logic [bfks_pkg::VAL_W-1:0]    rd_val_o
);

  logic [bfks_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [bfks_pkg::VAL_W-1:0] val_mem [DEPTH];
  logic [bfks_pkg::KEY_W-1:0] rd_key_q;
  logic [bfks_pkg::VAL_W-1:0] rd_val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_val_i;
    end
    // hold read data until the next read
    if (rd_en_i) begin
      rd_key_q <= key_mem[rd_addr_i];
      rd_val_q <= val_mem[rd_addr_i];
    end
  end

  assign rd_key_o = rd_key_q;
  assign rd_val_o = rd_val_q;

endmodule

// ----- src/bfks_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfks_ctrl: request sequencer
// Ring pointers, capacity register, scan sequencer with one shared key
// comparator, and the result register.
// ----------------------------------------------------------------------------
module bfks_ctrl #(
  parameter int unsigned DEPTH = bfks_pkg::DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bfks_req_if.sink                      req_i,
  bfks_rsp_if.source                    rsp_o,
  bfks_cfg_if.sink                      cfg_i,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic [bfks_pkg::KEY_W-1:0]    wr_key_o,
  output logic [bfks_pkg::VAL_W-1:0]    wr_val_o,
  output logic                          rd_en_o,
  output logic [AW-1:0]                 rd_addr_o,
  input  logic [bfks_pkg::KEY_W-1:0]    rd_key_i,
  input  logic [bfks_pkg::VAL_W-1:0]    rd_val_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [6:0] DEPTH_X = 7'(DEPTH);
  localparam logic [AW:0] DEPTH_S = (AW + 1)'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DATA,
    S_RD,
    S_CMP,
    S_FIN
  } state_e;

  state_e                          state_q, state_d;
  logic [AW-1:0]                   head_q, head_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [bfks_pkg::CAP_W-1:0]      cap_q, cap_d;
  bfks_pkg::req_t                  req_q, req_d;
  logic                            hit_q, hit_d;
  logic                            pend_q, pend_d;
  logic [bfks_pkg::KEY_W-1:0]      pkey_q, pkey_d;
  logic [bfks_pkg::VAL_W-1:0]      pval_q, pval_d;
  logic                            ovalid_q, ovalid_d;
  bfks_pkg::rsp_t                  rsp_q, rsp_d;

  logic       out_free;
  logic [6:0] cap_x, eff_cap;
  logic       full, pos_ok, match, advance;
  logic [CW-1:0] idx_nxt;
  logic [bfks_pkg::KEY_W-1:0] target;

  // ring slot of an offset from the head; sum stays below twice DEPTH
  function automatic logic [AW-1:0] slot(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [bfks_pkg::OCC_W-1:0] occ(logic [CW-1:0] c);
    logic [6:0] x;
    x = 7'(c);
    return x[bfks_pkg::OCC_W-1:0];
  endfunction

  assign out_free = !ovalid_q || rsp_o.ready;
  assign cap_x    = 7'(cap_q);
  assign eff_cap  = (cap_x == 7'd0 || cap_x > DEPTH_X) ? DEPTH_X : cap_x;
  assign full     = 7'(count_q) >= eff_cap;
  assign pos_ok   = 7'(req_q.position) < 7'(count_q);
  assign target   = (req_q.mode == bfks_pkg::MODE_REPLACE) ? req_q.old_key : req_q.key_in;
  assign match    = rd_key_i == target;
  assign idx_nxt  = idx_q + CW'(1);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    cap_d    = cap_q;
    req_d    = req_q;
    hit_d    = hit_q;
    pend_d   = pend_q;
    pkey_d   = pkey_q;
    pval_d   = pval_q;
    ovalid_d = ovalid_q;
    rsp_d    = rsp_q;
    advance  = 1'b1;

    wr_en_o   = 1'b0;
    wr_addr_o = slot(head_q, AW'(idx_q));
    wr_key_o  = req_q.key_in;
    wr_val_o  = req_q.value_word;
    rd_en_o   = 1'b0;
    rd_addr_o = slot(head_q, AW'(idx_q));

    if (ovalid_q && rsp_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d   = req_i.data;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (req_q.mode)
          bfks_pkg::MODE_PUSH: begin
            if (out_free) begin
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
              if (full) begin
                rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_FULL, '0, '0, occ(count_q), 1'b1);
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = slot(head_q, AW'(count_q));
                count_d   = count_q + CW'(1);
                rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_OK, '0, '0,
                                         occ(count_q + CW'(1)), 1'b1);
              end
            end
          end
          bfks_pkg::MODE_POP: begin
            if (count_q != '0) begin
              rd_en_o   = 1'b1;
              rd_addr_o = head_q;
              state_d   = S_DATA;
            end else if (out_free) begin
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
              rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_EMPTY, '0, '0, occ(count_q), 1'b1);
            end
          end
          bfks_pkg::MODE_SEARCH, bfks_pkg::MODE_REPLACE: begin
            idx_d   = '0;
            hit_d   = 1'b0;
            pend_d  = 1'b0;
            state_d = (count_q == '0) ? S_FIN : S_RD;
          end
          bfks_pkg::MODE_EDIT: begin
            if (out_free) begin
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
              if (pos_ok) begin
                wr_en_o   = 1'b1;
                wr_addr_o = slot(head_q, AW'(req_q.position));
                rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_OK, '0, '0, occ(count_q), 1'b1);
              end else begin
                rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_RANGE, '0, '0, occ(count_q), 1'b1);
              end
            end
          end
          bfks_pkg::MODE_READ: begin
            if (pos_ok) begin
              rd_en_o   = 1'b1;
              rd_addr_o = slot(head_q, AW'(req_q.position));
              state_d   = S_DATA;
            end else if (out_free) begin
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
              rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_RANGE, '0, '0, occ(count_q), 1'b1);
            end
          end
          bfks_pkg::MODE_CLEAR: begin
            if (out_free) begin
              head_d   = '0;
              count_d  = '0;
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
              rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_OK, '0, '0, '0, 1'b1);
            end
          end
          default: begin
            if (out_free) begin
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
              rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_OK, '0, '0, occ(count_q), 1'b1);
            end
          end
        endcase
      end

      S_DATA: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
          if (req_q.mode == bfks_pkg::MODE_POP) begin
            head_d  = slot(head_q, AW'(1));
            count_d = count_q - CW'(1);
            rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_OK, rd_key_i, rd_val_i,
                                     occ(count_q - CW'(1)), 1'b1);
          end else begin
            rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_OK, rd_key_i, rd_val_i,
                                     occ(count_q), 1'b1);
          end
        end
      end

      S_RD: begin
        rd_en_o = 1'b1;
        state_d = S_CMP;
      end

      S_CMP: begin
        if (match) begin
          if (req_q.mode == bfks_pkg::MODE_REPLACE) begin
            wr_en_o = 1'b1;
            hit_d   = 1'b1;
          end else if (!pend_q) begin
            pend_d = 1'b1;
            pkey_d = rd_key_i;
            pval_d = rd_val_i;
          end else if (out_free) begin
            // send the earlier match; it is not the final one
            ovalid_d = 1'b1;
            rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_OK, pkey_q, pval_q, occ(count_q), 1'b0);
            pkey_d = rd_key_i;
            pval_d = rd_val_i;
          end else begin
            advance = 1'b0;
          end
        end
        if (advance) begin
          idx_d   = idx_nxt;
          state_d = (idx_nxt == count_q) ? S_FIN : S_RD;
        end
      end

      S_FIN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
          if (req_q.mode == bfks_pkg::MODE_REPLACE) begin
            rsp_d = bfks_pkg::mk_rsp(hit_q ? bfks_pkg::ST_OK : bfks_pkg::ST_NOTFOUND,
                                     '0, '0, occ(count_q), 1'b1);
          end else if (pend_q) begin
            rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_OK, pkey_q, pval_q, occ(count_q), 1'b1);
          end else begin
            rsp_d = bfks_pkg::mk_rsp(bfks_pkg::ST_NOTFOUND, '0, '0, occ(count_q), 1'b1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // capacity write empties the queue
    if (cfg_i.valid) begin
      cap_d   = cfg_i.data;
      head_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      cap_q    <= bfks_pkg::CAP_RESET;
      req_q    <= '0;
      hit_q    <= 1'b0;
      pend_q   <= 1'b0;
      pkey_q   <= '0;
      pval_q   <= '0;
      ovalid_q <= 1'b0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      cap_q    <= cap_d;
      req_q    <= req_d;
      hit_q    <= hit_d;
      pend_q   <= pend_d;
      pkey_q   <= pkey_d;
      pval_q   <= pval_d;
      ovalid_q <= ovalid_d;
      rsp_q    <= rsp_d;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = ovalid_q;
  assign rsp_o.data  = rsp_q;

endmodule

// ----- src/bounded_fifo_with_key_search_top.sv -----
// ----------------------------------------------------------------------------
// bounded_fifo_with_key_search_top: bounded key/value queue with key search
// Ring of DEPTH key/value entries with push, pop, search, replace, positional
// edit/read and clear requests, and a run-time capacity register.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one request per transfer (mode, key_in, old_key, value_word,
//            position). ready is high only while the sequencer is idle.
//   rsp_o  : result transfers; every request yields one result, except search,
//            which yields one per matching entry from the head, last marking
//            the final one, or a single not-found result.
//   cfg_i  : capacity write, always ready; any write empties the queue. Write
//            only while no request is in flight.
// Sequence: push, edit, clear and undefined modes load the result straight
//   from the registered request; pop and read first fetch the entry with one
//   memory read, except on an empty queue or an out-of-range position.
//   Search and replace walk the ring from the head with a single shared key
//   comparator, one memory read and one compare per stored entry. The next
//   request is taken once the final result is in the result register.
// Stall: a result waits in the output register; the sequencer holds when it
//   needs to load another result while that register is still full.
// Reset: queue empty, head at slot 0, capacity 16. Entry memory is not
//   cleared; only slots below the occupancy are ever read.
// ----------------------------------------------------------------------------
module bounded_fifo_with_key_search_top #(
  parameter int unsigned DEPTH = bfks_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfks_req_if.sink    req_i,
  bfks_rsp_if.source  rsp_o,
  bfks_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // memory ports between sequencer and entry store
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [bfks_pkg::KEY_W-1:0]  wr_key;
  logic [bfks_pkg::VAL_W-1:0]  wr_val;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [bfks_pkg::KEY_W-1:0]  rd_key;
  logic [bfks_pkg::VAL_W-1:0]  rd_val;

  // sequencer: pointers, capacity, scan and result register
  bfks_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .cfg_i     (cfg_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_key_o  (wr_key),
    .wr_val_o  (wr_val),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_key_i  (rd_key),
    .rd_val_i  (rd_val)
  );

  // entry store: one write, one registered read per cycle
  bfks_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_val_i  (wr_val),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_val_o  (rd_val)
  );

endmodule
